// ===== src/nna_pkg.sv =====
// shared constants and types for the nearest neighbour anomaly scorer
package nna_pkg;

   localparam int REF_COUNT    = 8;
   localparam int NUM_FEATURES = 5;
   localparam int SAMPLE_W     = 16;
   localparam int DIST_W       = 35;
   localparam int SQ_W         = 32;
   localparam int ROW_W        = (REF_COUNT > 1) ? $clog2(REF_COUNT) : 1;
   localparam int ROW_DATA_W   = NUM_FEATURES * SAMPLE_W;

   localparam logic       OP_LOAD     = 1'b0;
   localparam logic       OP_CLASSIFY = 1'b1;

   localparam logic       REG_REFS_IN_USE  = 1'b0;
   localparam logic       REG_THRESHOLD_SQ = 1'b1;

   localparam logic [3:0]        REFS_IN_USE_RESET  = 4'd5;
   localparam logic [DIST_W-1:0] THRESHOLD_SQ_RESET = 35'd65536;

   typedef logic [SAMPLE_W-1:0] sample_type;
   typedef logic [ROW_W-1:0]    row_type;

endpackage

// ===== src/nna_ram.sv =====
// generic single write port ram with registered read
module nna_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 8
) (
   input  logic                                   clock,
   input  logic                                   wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                       wr_data,
   input  logic                                   rd_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                       rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== src/nearest_neighbour_anomaly_score.sv =====
// nearest neighbour anomaly scorer: row ram, distance pipeline and sequencer
//
//  channel   ports                                        moves
//  req       req_valid req_ready req_operation ...        load or classify item
//  rsp       rsp_valid rsp_ready rsp_min_distance_sq ...  one item per classify
//  csr       csr_write_enable csr_index csr_write_data    register write
//
// a load gives no item; a classify streams the rows in use, one row per
// cycle, through the shared distance pipeline (row ram read, abs diff,
// square, sum, compare).
// reset clears control and registers; the row ram is not cleared.
// a waiting rsp item does not block the next req item, only the next finish.
module nearest_neighbour_anomaly_score
   import nna_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic              req_operation,
   input  logic [2:0]        req_ref_slot,
   input  logic [15:0]       req_feature_0,
   input  logic [15:0]       req_feature_1,
   input  logic [15:0]       req_feature_2,
   input  logic [15:0]       req_feature_3,
   input  logic [15:0]       req_feature_4,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [34:0]       rsp_min_distance_sq,
   output logic [2:0]        rsp_nearest_slot,
   output logic              rsp_anomaly,
   input  logic              csr_write_enable,
   input  logic              csr_index,
   input  logic [34:0]       csr_write_data
);

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_RUN    = 2'd1;
   localparam logic [1:0] ST_FINISH = 2'd2;

   logic [1:0]        state_ff, state_in;
   logic [3:0]        refs_in_use_ff;
   logic [DIST_W-1:0] threshold_sq_ff;

   sample_type        query_ff [NUM_FEATURES];
   sample_type        req_feature [NUM_FEATURES];

   logic              issue_active_ff, issue_active_in;
   row_type           issue_row_ff, issue_row_in;
   row_type           last_row;

   logic              s1_valid_ff, s1_last_ff;
   row_type           s1_row_ff;
   logic              s2_valid_ff, s2_last_ff;
   row_type           s2_row_ff;
   sample_type        s2_abs_ff [NUM_FEATURES];
   logic              s3_valid_ff, s3_last_ff;
   row_type           s3_row_ff;
   logic [SQ_W-1:0]   s3_sq_ff [NUM_FEATURES];
   logic              s4_valid_ff, s4_last_ff;
   row_type           s4_row_ff;
   logic [DIST_W-1:0] s4_sum_ff;
   logic [DIST_W-1:0] sum_in;

   logic [DIST_W-1:0] best_ff;
   row_type           best_row_ff;

   logic              rsp_valid_ff;
   logic [DIST_W-1:0] rsp_dist_ff;
   logic [2:0]        rsp_slot_ff;
   logic              rsp_anomaly_ff;

   logic              req_accept;
   logic              ram_wr_en;
   logic              issue;
   logic              rsp_free;
   logic [ROW_DATA_W-1:0] ram_wr_data;
   logic [ROW_DATA_W-1:0] ram_rd_data;

   assign req_feature[0] = req_feature_0;
   assign req_feature[1] = req_feature_1;
   assign req_feature[2] = req_feature_2;
   assign req_feature[3] = req_feature_3;
   assign req_feature[4] = req_feature_4;

   assign req_ready  = (state_ff == ST_IDLE);
   assign req_accept = req_valid && req_ready;
   assign ram_wr_en  = req_accept && (req_operation == OP_LOAD)
                       && (32'(req_ref_slot) < REF_COUNT);
   assign ram_wr_data = {req_feature_4, req_feature_3, req_feature_2,
                         req_feature_1, req_feature_0};
   assign issue    = (state_ff == ST_RUN) && issue_active_ff;
   assign rsp_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      if (refs_in_use_ff == 4'd0) begin
         last_row = '0;
      end else if (32'(refs_in_use_ff) > REF_COUNT) begin
         last_row = ROW_W'(REF_COUNT - 1);
      end else begin
         last_row = ROW_W'(refs_in_use_ff - 4'd1);
      end
   end

   nna_ram #(
      .WIDTH(ROW_DATA_W),
      .DEPTH(REF_COUNT)
   ) u_ref_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ROW_W'(req_ref_slot)),
      .wr_data (ram_wr_data),
      .rd_en   (issue),
      .rd_addr (issue_row_ff),
      .rd_data (ram_rd_data)
   );

   // sequencer
   always_comb begin
      state_in        = state_ff;
      issue_active_in = issue_active_ff;
      issue_row_in    = issue_row_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept && (req_operation == OP_CLASSIFY)) begin
               state_in        = ST_RUN;
               issue_active_in = 1'b1;
               issue_row_in    = '0;
            end
         end
         ST_RUN: begin
            if (issue) begin
               if (issue_row_ff == last_row) begin
                  issue_active_in = 1'b0;
               end else begin
                  issue_row_in = issue_row_ff + 1'b1;
               end
            end
            if (s4_valid_ff && s4_last_ff) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         issue_active_ff <= 1'b0;
         issue_row_ff    <= '0;
         s1_valid_ff     <= 1'b0;
         s2_valid_ff     <= 1'b0;
         s3_valid_ff     <= 1'b0;
         s4_valid_ff     <= 1'b0;
         refs_in_use_ff  <= REFS_IN_USE_RESET;
         threshold_sq_ff <= THRESHOLD_SQ_RESET;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff        <= state_in;
         issue_active_ff <= issue_active_in;
         issue_row_ff    <= issue_row_in;
         s1_valid_ff     <= issue;
         s2_valid_ff     <= s1_valid_ff;
         s3_valid_ff     <= s2_valid_ff;
         s4_valid_ff     <= s3_valid_ff;
         if (csr_write_enable) begin
            unique case (csr_index)
               REG_REFS_IN_USE:  refs_in_use_ff  <= csr_write_data[3:0];
               REG_THRESHOLD_SQ: threshold_sq_ff <= csr_write_data;
               default:          refs_in_use_ff  <= refs_in_use_ff;
            endcase
         end
         if ((state_ff == ST_FINISH) && rsp_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // distance pipeline
   always_comb begin
      sum_in = '0;
      for (int i = 0; i < NUM_FEATURES; i++) begin
         sum_in = sum_in + DIST_W'(s3_sq_ff[i]);
      end
   end

   always_ff @(posedge clock) begin
      logic signed [SAMPLE_W:0] diff;
      logic signed [SAMPLE_W:0] mag;
      if (req_accept) begin
         for (int i = 0; i < NUM_FEATURES; i++) begin
            query_ff[i] <= req_feature[i];
         end
      end
      s1_row_ff  <= issue_row_ff;
      s1_last_ff <= (issue_row_ff == last_row);
      s2_row_ff  <= s1_row_ff;
      s2_last_ff <= s1_last_ff;
      for (int i = 0; i < NUM_FEATURES; i++) begin
         diff = $signed({query_ff[i][SAMPLE_W-1], query_ff[i]})
              - $signed({ram_rd_data[SAMPLE_W*i+SAMPLE_W-1],
                         ram_rd_data[SAMPLE_W*i +: SAMPLE_W]});
         mag  = diff[SAMPLE_W] ? -diff : diff;
         s2_abs_ff[i] <= mag[SAMPLE_W-1:0];
      end
      s3_row_ff  <= s2_row_ff;
      s3_last_ff <= s2_last_ff;
      for (int i = 0; i < NUM_FEATURES; i++) begin
         s3_sq_ff[i] <= SQ_W'(s2_abs_ff[i]) * SQ_W'(s2_abs_ff[i]);
      end
      s4_row_ff  <= s3_row_ff;
      s4_last_ff <= s3_last_ff;
      s4_sum_ff  <= sum_in;
      if (s4_valid_ff && ((s4_row_ff == '0) || (s4_sum_ff < best_ff))) begin
         best_ff     <= s4_sum_ff;
         best_row_ff <= s4_row_ff;
      end
      if ((state_ff == ST_FINISH) && rsp_free) begin
         rsp_dist_ff    <= best_ff;
         rsp_slot_ff    <= 3'(best_row_ff);
         rsp_anomaly_ff <= (best_ff > threshold_sq_ff);
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_min_distance_sq = rsp_dist_ff;
   assign rsp_nearest_slot    = rsp_slot_ff;
   assign rsp_anomaly         = rsp_anomaly_ff;

endmodule

// ===== tb/tb.sv =====
// self-checking testbench for the nearest neighbour anomaly scorer
`timescale 1ns / 100ps

module tb;
   import nna_pkg::*;

   localparam int  CYCLE_LIMIT  = 400000;
   localparam int  DRAIN_CYCLES = 24;
   localparam int  PHASES       = 6;
   localparam int  PHASE_ITEMS  = 245;
   localparam longint MAX_DIST  = 64'd21474181125;

   typedef logic [NUM_FEATURES-1:0][SAMPLE_W-1:0] vector_type;

   typedef struct packed {
      logic       operation;
      logic [2:0] ref_slot;
      vector_type feature;
   } query_item_type;

   typedef struct packed {
      logic [DIST_W-1:0] distance;
      row_type           slot;
      logic              anomaly;
   } score_type;

   typedef struct packed {
      query_item_type item;
      logic           typed;
      score_type      want;
   } table_row_type;

   logic              clock = 1'b0;
   logic              reset;
   logic              req_valid;
   logic              req_ready;
   logic              req_operation;
   logic [2:0]        req_ref_slot;
   logic [15:0]       req_feature_0;
   logic [15:0]       req_feature_1;
   logic [15:0]       req_feature_2;
   logic [15:0]       req_feature_3;
   logic [15:0]       req_feature_4;
   logic              rsp_valid;
   logic              rsp_ready;
   logic [34:0]       rsp_min_distance_sq;
   logic [2:0]        rsp_nearest_slot;
   logic              rsp_anomaly;
   logic              csr_write_enable;
   logic              csr_index;
   logic [34:0]       csr_write_data;

   vector_type        ref_rows [REF_COUNT];
   logic [3:0]        rows_reg;
   logic [DIST_W-1:0] thresh_reg;
   score_type         pending_scores [$];
   table_row_type     stim_table [$];
   int                mismatch_count = 0;
   int                cycle_count = 0;
   bit                idling_on;

   nearest_neighbour_anomaly_score uut (.*);

   always #10 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("TEST FAILED");
         $finish;
      end
   end

   function automatic int rows_used();
      if (rows_reg == 0) return 1;
      if (rows_reg > REF_COUNT) return REF_COUNT;
      return int'(rows_reg);
   endfunction

   function automatic score_type score_query(input query_item_type it);
      score_type s;
      longint best, row_sum, diff;
      best = 0;
      s = '0;
      for (int r = 0; r < rows_used(); r++) begin
         row_sum = 0;
         for (int f = 0; f < NUM_FEATURES; f++) begin
            diff = longint'($signed(it.feature[f])) - longint'($signed(ref_rows[r][f]));
            row_sum += diff * diff;
         end
         if (r == 0 || row_sum < best) begin
            best = row_sum;
            s.slot = row_type'(r);
         end
      end
      s.distance = best[DIST_W-1:0];
      s.anomaly = (best > longint'(thresh_reg));
      return s;
   endfunction

   function automatic query_item_type random_item();
      query_item_type it;
      int base, pick;
      it.operation = ($urandom_range(0, 99) < 45) ? OP_LOAD : OP_CLASSIFY;
      it.ref_slot = 3'($urandom);
      base = $urandom_range(0, rows_used() - 1);
      pick = $urandom_range(0, 7);
      for (int f = 0; f < NUM_FEATURES; f++) begin
         case (pick)
            0: it.feature[f] = ref_rows[base][f];
            1, 2: it.feature[f] = ref_rows[base][f] + 16'($urandom_range(0, 600) - 300);
            3: it.feature[f] = $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
            4: it.feature[f] = 16'($urandom_range(0, 1023) - 512);
            default: it.feature[f] = 16'($urandom);
         endcase
      end
      return it;
   endfunction

   task automatic note_error(input string msg);
      mismatch_count++;
      if (mismatch_count <= 10) $display("%0t: %s", $time, msg);
   endtask

   // runs at the edge where the item is taken
   task automatic record_item(input query_item_type it, input logic typed,
                              input score_type want);
      if (it.operation == OP_LOAD) begin
         if (int'(it.ref_slot) < REF_COUNT) ref_rows[it.ref_slot] = it.feature;
      end else begin
         pending_scores.push_back(typed ? want : score_query(it));
      end
   endtask

   task automatic send_item(input query_item_type it, input logic typed,
                            input score_type want);
      if (idling_on && $urandom_range(0, 9) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 19)) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_operation <= it.operation;
      req_ref_slot  <= it.ref_slot;
      req_feature_0 <= it.feature[0];
      req_feature_1 <= it.feature[1];
      req_feature_2 <= it.feature[2];
      req_feature_3 <= it.feature[3];
      req_feature_4 <= it.feature[4];
      do @(posedge clock); while (!req_ready);
      record_item(it, typed, want);
   endtask

   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_scores.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic index, input logic [34:0] data);
      csr_write_enable <= 1'b1;
      csr_index        <= index;
      csr_write_data   <= data;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      if (index == REG_REFS_IN_USE) rows_reg = data[3:0];
      else thresh_reg = data;
      @(posedge clock);
   endtask

   task automatic add_row(input logic op, input logic [2:0] slot, input vector_type f,
                          input logic typed, input score_type want);
      table_row_type row;
      row.item.operation = op;
      row.item.ref_slot = slot;
      row.item.feature = f;
      row.typed = typed;
      row.want = want;
      stim_table.push_back(row);
   endtask

   task automatic check_score();
      score_type got, want;
      got = {rsp_min_distance_sq, rsp_nearest_slot, rsp_anomaly};
      if (pending_scores.size() == 0) begin
         note_error($sformatf("unexpected item: dist %0d slot %0d anomaly %0b",
                              got.distance, got.slot, got.anomaly));
      end else begin
         want = pending_scores.pop_front();
         if (got.distance !== want.distance || got.slot !== want.slot
             || got.anomaly !== want.anomaly)
            note_error($sformatf("expected dist %0d slot %0d anomaly %0b, got %0d %0d %0b",
                                 want.distance, want.slot, want.anomaly,
                                 got.distance, got.slot, got.anomaly));
      end
   endtask

   initial begin
      int stall_left;
      stall_left = 0;
      rsp_ready = 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && rsp_ready) check_score();
         if (stall_left > 0) stall_left--;
         else if (idling_on && $urandom_range(0, 11) == 0) stall_left = $urandom_range(1, 19);
         rsp_ready <= (stall_left == 0) && !reset;
      end
   end

   initial begin
      logic [3:0]  refs;
      logic [34:0] thr;
      logic [34:0] data;
      query_item_type extreme;
      reset = 1'b1;
      req_valid = 1'b0;
      req_operation = OP_LOAD;
      req_ref_slot = '0;
      req_feature_0 = '0;
      req_feature_1 = '0;
      req_feature_2 = '0;
      req_feature_3 = '0;
      req_feature_4 = '0;
      csr_write_enable = 1'b0;
      csr_index = REG_REFS_IN_USE;
      csr_write_data = '0;
      idling_on = 1'b1;
      rows_reg = REFS_IN_USE_RESET;
      thresh_reg = THRESHOLD_SQ_RESET;
      for (int r = 0; r < REF_COUNT; r++) ref_rows[r] = '0;

      // every row is loaded before the first classify
      add_row(OP_LOAD, 3'd0, '0, 1'b0, '0);
      add_row(OP_LOAD, 3'd1, {5{16'h7FFF}}, 1'b0, '0);
      add_row(OP_LOAD, 3'd2, {5{16'h8000}}, 1'b0, '0);
      add_row(OP_LOAD, 3'd3, '0, 1'b0, '0);
      add_row(OP_LOAD, 3'd4, {16'h0001, 16'hFE00, 16'h0200, 16'hFF00, 16'h0100}, 1'b0, '0);
      add_row(OP_LOAD, 3'd5, {5{16'h7FFF}}, 1'b0, '0);
      add_row(OP_LOAD, 3'd6, {5{16'h5555}}, 1'b0, '0);
      add_row(OP_LOAD, 3'd7, {5{16'hAAAA}}, 1'b0, '0);
      add_row(OP_CLASSIFY, 3'd0, '0, 1'b1, {35'd0, 3'd0, 1'b0});
      add_row(OP_CLASSIFY, 3'd3, {5{16'h7FFF}}, 1'b1, {35'd0, 3'd1, 1'b0});
      add_row(OP_CLASSIFY, 3'd6, {5{16'h8000}}, 1'b1, {35'd0, 3'd2, 1'b0});
      add_row(OP_CLASSIFY, 3'd1, {16'h0001, 16'hFE00, 16'h0200, 16'hFF00, 16'h0100},
              1'b1, {35'd0, 3'd4, 1'b0});
      add_row(OP_CLASSIFY, 3'd0, 80'h100, 1'b1, {35'd65536, 3'd0, 1'b0});
      add_row(OP_CLASSIFY, 3'd0, 80'h101, 1'b1, {35'd66049, 3'd0, 1'b1});
      add_row(OP_CLASSIFY, 3'd7, {5{16'h5555}}, 1'b0, '0);
      add_row(OP_CLASSIFY, 3'd5, {5{16'hAAAA}}, 1'b0, '0);
      add_row(OP_CLASSIFY, 3'd2, {16'h8000, 16'h7FFF, 16'h0000, 16'hFFFF, 16'h0001}, 1'b0, '0);

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      foreach (stim_table[i]) send_item(stim_table[i].item, stim_table[i].typed,
                                        stim_table[i].want);

      for (int p = 0; p < PHASES; p++) begin
         case (p)
            0: begin refs = 4'd8;  thr = 35'd262144; end
            1: begin refs = 4'd0;  thr = MAX_DIST[34:0]; end
            2: begin refs = 4'd1;  thr = MAX_DIST[34:0] - 35'd1; end
            3: begin refs = 4'd15; thr = '0; end
            4: begin refs = 4'd3;  thr = '1; end
            default: begin refs = 4'($urandom); thr = 35'({$urandom, $urandom}); end
         endcase
         settle();
         if (p == PHASES - 1) idling_on = 1'b0;
         data = 35'({$urandom, $urandom});
         data[3:0] = refs;
         write_reg(REG_REFS_IN_USE, data);
         write_reg(REG_THRESHOLD_SQ, thr);
         if (p == 1 || p == 2) begin
            // largest possible distance, either side of the threshold
            extreme.operation = OP_LOAD;
            extreme.ref_slot = 3'd0;
            extreme.feature = {5{16'h8000}};
            send_item(extreme, 1'b0, '0);
            extreme.operation = OP_CLASSIFY;
            extreme.feature = {5{16'h7FFF}};
            send_item(extreme, 1'b0, '0);
         end
         repeat (PHASE_ITEMS) send_item(random_item(), 1'b0, '0);
      end

      settle();
      if (mismatch_count == 0 && pending_scores.size() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
src/nna_pkg.sv
src/nna_ram.sv
src/nearest_neighbour_anomaly_score.sv
tb/tb.sv
